// ===== src/sklf_pkg.sv =====
// Package for the scalar Kalman filter: item types, register indexes, control types.
`timescale 1ns / 1ps

package sklf_pkg;

    // Sample and register formats
    localparam int SAMPLE_WIDTH  = 16;
    localparam int CFG_WIDTH     = 16;
    localparam int CFG_IDX_WIDTH = 2;
    localparam int VAR_WIDTH     = 32;

    // Register indexes
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_PROCESS_NOISE     = 2'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_MEASUREMENT_NOISE = 2'd1;

    // Reset values of the noise registers (unsigned Q8.8)
    localparam logic [CFG_WIDTH-1:0] PROCESS_NOISE_RESET     = 16'd26;
    localparam logic [CFG_WIDTH-1:0] MEASUREMENT_NOISE_RESET = 16'd256;

    // Input item
    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] measurement;
        logic                           restart;
    } sample_t;

    // Result item
    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] estimate;
        logic                           was_initialization;
    } result_t;

    // Controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INIT,
        ST_PREDICT,
        ST_DENOM,
        ST_DIV_INT,
        ST_DIV_STEP,
        ST_MULT,
        ST_UPDATE,
        ST_OUTPUT
    } ctrl_state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;
        logic init_load;
        logic predict;
        logic denom;
        logic div_init;
        logic div_step;
        logic mult;
        logic update;
        logic out_load;
    } dp_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic needs_init;
    } dp_status_t;

endpackage

// ===== src/scalar_kalman_filter.sv =====
// Top level of the scalar random-walk Kalman filter for signal-strength samples.
//
//   Channel   Handshake                    Payload
//   sample    sample_valid / sample_stall  sample_item  (measurement Q8.8, restart)
//   result    result_valid / result_stall  result_item  (estimate Q8.8, was_initialization)
//   config    cfg_we                       cfg_index, cfg_data (q and r, Q8.8)
//
// A filter step runs predict, the denominator, the integer quotient bit and the
// restoring divider that forms one gain bit per cycle, then multiply and update;
// the output state then loads the result and returns to idle for the next item.
// Reset clears the estimate, the variance and the initialized flag; q and r return
// to 26 and 256. The result register lets the next item be accepted while a
// result waits under result_stall; the finished item then waits for it.
`timescale 1ns / 1ps

module scalar_kalman_filter #(
    parameter int GAIN_FRACTION_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                sample_valid,
    output logic                                sample_stall,
    input  sklf_pkg::sample_t                   sample_item,
    output logic                                result_valid,
    input  logic                                result_stall,
    output sklf_pkg::result_t                   result_item,
    input  logic                                cfg_we,
    input  logic [sklf_pkg::CFG_IDX_WIDTH-1:0]  cfg_index,
    input  logic [sklf_pkg::CFG_WIDTH-1:0]      cfg_data
);

    sklf_pkg::dp_cmd_t    cmd;
    sklf_pkg::dp_status_t status;

    sklf_ctrl #(
        .GAIN_FRACTION_BITS(GAIN_FRACTION_BITS)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .status       (status),
        .cmd          (cmd)
    );

    sklf_dp #(
        .GAIN_FRACTION_BITS(GAIN_FRACTION_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .sample_item (sample_item),
        .cmd         (cmd),
        .status      (status),
        .result_item (result_item)
    );

endmodule

// ===== src/sklf_dp.sv =====
// Datapath of the scalar Kalman filter: noise registers, state, divider, multipliers.
`timescale 1ns / 1ps

module sklf_dp #(
    parameter int GAIN_FRACTION_BITS = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [sklf_pkg::CFG_IDX_WIDTH-1:0]   cfg_index,
    input  logic [sklf_pkg::CFG_WIDTH-1:0]       cfg_data,
    input  sklf_pkg::sample_t                    sample_item,
    input  sklf_pkg::dp_cmd_t                    cmd,
    output sklf_pkg::dp_status_t                 status,
    output sklf_pkg::result_t                    result_item
);

    localparam int G   = GAIN_FRACTION_BITS;
    localparam int SW  = sklf_pkg::SAMPLE_WIDTH;
    localparam int VW  = sklf_pkg::VAR_WIDTH;
    localparam int PW  = G + SW + 2;   // gain times difference
    localparam int RW  = PW + 1;       // rounded product
    localparam int XW  = SW + 3;       // widened estimate sum
    localparam int MW  = G + 1 + VW;   // variance product

    localparam logic [G:0]             GainOne   = {1'b1, {G{1'b0}}};
    localparam logic signed [RW-1:0]   RoundHalf = {{(SW+3){1'b0}}, 1'b1, {(G-1){1'b0}}};
    localparam logic signed [XW-1:0]   XMax      = {4'b0000, {(SW-1){1'b1}}};
    localparam logic signed [XW-1:0]   XMin      = {4'b1111, {(SW-1){1'b0}}};

    // Registers
    logic [sklf_pkg::CFG_WIDTH-1:0] q_reg, q_next;
    logic [sklf_pkg::CFG_WIDTH-1:0] r_reg, r_next;
    logic signed [SW-1:0]           m_reg, m_next;
    logic signed [SW-1:0]           x_reg, x_next;
    logic [VW-1:0]                  p_reg, p_next;
    logic                           init_reg, init_next;
    logic                           flag_reg, flag_next;
    logic [VW-1:0]                  pp_reg, pp_next;
    logic [VW:0]                    den_reg, den_next;
    logic [VW:0]                    rem_reg, rem_next;
    logic [G:0]                     quot_reg, quot_next;
    logic signed [PW-1:0]           gprod_reg, gprod_next;
    logic [MW-1:0]                  vprod_reg, vprod_next;
    sklf_pkg::result_t              result_reg, result_next;

    // Combinational terms
    logic [VW:0]          pred_sum;
    logic [VW+1:0]        shifted_rem;
    logic [VW+1:0]        step_diff;
    logic                 int_ge;
    logic                 step_ge;
    logic [G-1:0]         gain;
    logic signed [G:0]    gain_s;
    logic [G:0]           one_minus_gain;
    logic signed [SW:0]   diff;
    logic signed [RW-1:0] rounded;
    logic signed [RW-1:0] rounded_sh;
    logic signed [XW-1:0] step;
    logic signed [XW-1:0] x_sum;
    logic signed [SW-1:0] x_clamped;

    assign status.needs_init = sample_item.restart || !init_reg;
    assign result_item       = result_reg;

    // Prediction, divider compare and gain
    always_comb
    begin
        pred_sum       = {1'b0, p_reg} + {9'd0, q_reg, 8'd0};
        int_ge         = ({1'b0, pp_reg} >= den_reg);
        shifted_rem    = {rem_reg, 1'b0};
        step_ge        = (shifted_rem >= {1'b0, den_reg});
        step_diff      = shifted_rem - {1'b0, den_reg};
        gain           = quot_reg[G] ? {G{1'b1}} : quot_reg[G-1:0];
        gain_s         = $signed({1'b0, gain});
        one_minus_gain = GainOne - {1'b0, gain};
        diff           = $signed({m_reg[SW-1], m_reg}) - $signed({x_reg[SW-1], x_reg});
    end

    // Estimate update: round half up, floor shift, clamp
    always_comb
    begin
        rounded    = $signed({gprod_reg[PW-1], gprod_reg}) + RoundHalf;
        rounded_sh = rounded >>> G;
        step       = $signed(rounded_sh[XW-1:0]);
        x_sum      = $signed({{3{x_reg[SW-1]}}, x_reg}) + step;
        if (x_sum > XMax)
        begin
            x_clamped = XMax[SW-1:0];
        end
        else if (x_sum < XMin)
        begin
            x_clamped = XMin[SW-1:0];
        end
        else
        begin
            x_clamped = x_sum[SW-1:0];
        end
    end

    // Next-state logic
    always_comb
    begin
        q_next      = q_reg;
        r_next      = r_reg;
        m_next      = m_reg;
        x_next      = x_reg;
        p_next      = p_reg;
        init_next   = init_reg;
        flag_next   = flag_reg;
        pp_next     = pp_reg;
        den_next    = den_reg;
        rem_next    = rem_reg;
        quot_next   = quot_reg;
        gprod_next  = gprod_reg;
        vprod_next  = vprod_reg;
        result_next = result_reg;

        // configuration writes; other indexes are ignored
        if (cfg_we && (cfg_index == sklf_pkg::CFG_PROCESS_NOISE))
        begin
            q_next = cfg_data;
        end
        if (cfg_we && (cfg_index == sklf_pkg::CFG_MEASUREMENT_NOISE))
        begin
            r_next = cfg_data;
        end

        if (cmd.capture)
        begin
            m_next = sample_item.measurement;
        end

        // initialization: load estimate, variance from measurement noise
        if (cmd.init_load)
        begin
            x_next    = m_reg;
            p_next    = {8'd0, r_reg, 8'd0};
            init_next = 1'b1;
            flag_next = 1'b1;
        end

        // p + q, saturating
        if (cmd.predict)
        begin
            pp_next = pred_sum[VW] ? {VW{1'b1}} : pred_sum[VW-1:0];
        end

        if (cmd.denom)
        begin
            den_next = {1'b0, pp_reg} + {9'd0, r_reg, 8'd0};
        end

        // integer quotient bit
        if (cmd.div_init)
        begin
            rem_next  = int_ge ? ({1'b0, pp_reg} - den_reg) : {1'b0, pp_reg};
            quot_next = {{G{1'b0}}, int_ge};
        end

        // one fraction bit per step
        if (cmd.div_step)
        begin
            rem_next  = step_ge ? step_diff[VW:0] : shifted_rem[VW:0];
            quot_next = {quot_reg[G-1:0], step_ge};
        end

        if (cmd.mult)
        begin
            gprod_next = PW'(gain_s) * PW'(diff);
            vprod_next = MW'(one_minus_gain) * MW'(pp_reg);
        end

        if (cmd.update)
        begin
            x_next    = x_clamped;
            p_next    = vprod_reg[G+VW-1:G];
            flag_next = 1'b0;
        end

        if (cmd.out_load)
        begin
            result_next.estimate           = x_reg;
            result_next.was_initialization = flag_reg;
        end
    end

    // Control and filter state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_reg    <= sklf_pkg::PROCESS_NOISE_RESET;
            r_reg    <= sklf_pkg::MEASUREMENT_NOISE_RESET;
            x_reg    <= '0;
            p_reg    <= '0;
            init_reg <= 1'b0;
        end
        else
        begin
            q_reg    <= q_next;
            r_reg    <= r_next;
            x_reg    <= x_next;
            p_reg    <= p_next;
            init_reg <= init_next;
        end
    end

    // Working payload registers
    always_ff @(posedge clk)
    begin
        m_reg      <= m_next;
        flag_reg   <= flag_next;
        pp_reg     <= pp_next;
        den_reg    <= den_next;
        rem_reg    <= rem_next;
        quot_reg   <= quot_next;
        gprod_reg  <= gprod_next;
        vprod_reg  <= vprod_next;
        result_reg <= result_next;
    end

endmodule

// ===== src/sklf_ctrl.sv =====
// Controller of the scalar Kalman filter: sequencing, divider step count, result valid.
`timescale 1ns / 1ps

module sklf_ctrl #(
    parameter int GAIN_FRACTION_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  sample_valid,
    output logic                  sample_stall,
    output logic                  result_valid,
    input  logic                  result_stall,
    input  sklf_pkg::dp_status_t  status,
    output sklf_pkg::dp_cmd_t     cmd
);

    localparam int CW = $clog2(GAIN_FRACTION_BITS);

    sklf_pkg::ctrl_state_t state_reg, state_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic                  valid_reg, valid_next;
    logic                  out_free;

    assign sample_stall = (state_reg != sklf_pkg::ST_IDLE);
    assign result_valid = valid_reg;
    assign out_free     = !valid_reg || !result_stall;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sklf_pkg::ST_IDLE;
            cnt_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            valid_reg <= valid_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;

        case (state_reg)
            sklf_pkg::ST_IDLE:
            begin
                if (sample_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = status.needs_init ? sklf_pkg::ST_INIT
                                                    : sklf_pkg::ST_PREDICT;
                end
            end
            sklf_pkg::ST_INIT:
            begin
                cmd.init_load = 1'b1;
                state_next    = sklf_pkg::ST_OUTPUT;
            end
            sklf_pkg::ST_PREDICT:
            begin
                cmd.predict = 1'b1;
                state_next  = sklf_pkg::ST_DENOM;
            end
            sklf_pkg::ST_DENOM:
            begin
                cmd.denom  = 1'b1;
                state_next = sklf_pkg::ST_DIV_INT;
            end
            sklf_pkg::ST_DIV_INT:
            begin
                cmd.div_init = 1'b1;
                cnt_next     = CW'(GAIN_FRACTION_BITS - 1);
                state_next   = sklf_pkg::ST_DIV_STEP;
            end
            sklf_pkg::ST_DIV_STEP:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg - CW'(1);
                if (cnt_reg == '0)
                begin
                    state_next = sklf_pkg::ST_MULT;
                end
            end
            sklf_pkg::ST_MULT:
            begin
                cmd.mult   = 1'b1;
                state_next = sklf_pkg::ST_UPDATE;
            end
            sklf_pkg::ST_UPDATE:
            begin
                // commit new estimate and shrunk variance
                cmd.update = 1'b1;
                state_next = sklf_pkg::ST_OUTPUT;
            end
            sklf_pkg::ST_OUTPUT:
            begin
                // hold the finished item until the result register is free
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = sklf_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sklf_pkg::ST_IDLE;
            end
        endcase
    end

    // Result valid: set on load, cleared when the item is taken
    always_comb
    begin
        valid_next = valid_reg;
        if (valid_reg && !result_stall)
        begin
            valid_next = 1'b0;
        end
        if (cmd.out_load)
        begin
            valid_next = 1'b1;
        end
    end

endmodule

// ===== test/scalar_kalman_filter_tb.sv =====
// Testbench for the scalar Kalman filter: directed and random samples checked against a predictor.
`timescale 1ns / 1ps

module scalar_kalman_filter_tb;

    // Gain and clamp constants of the filter arithmetic
    localparam int          GAIN_BITS = 16;
    localparam int          CFG_BITS  = sklf_pkg::CFG_WIDTH;
    localparam logic [63:0] GAIN_ONE  = 64'd1 << GAIN_BITS;
    localparam logic [63:0] GAIN_MAX  = GAIN_ONE - 64'd1;
    localparam logic [63:0] VAR_MAX   = 64'hFFFF_FFFF;
    localparam longint      EST_MAX   = (longint'(1) << (sklf_pkg::SAMPLE_WIDTH - 1)) - 1;
    localparam longint      EST_MIN   = -EST_MAX - 1;
    localparam int          STEP_LATENCY = GAIN_BITS + 7;

    // Register indexes outside the list; writes there must be ignored
    localparam logic [sklf_pkg::CFG_IDX_WIDTH-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [sklf_pkg::CFG_IDX_WIDTH-1:0] CFG_SPARE_B = 2'd3;

    logic                               clk = 1'b0;
    logic                               rst_n;
    logic                               sample_valid;
    logic                               sample_stall;
    sklf_pkg::sample_t                  sample_item;
    logic                               result_valid;
    logic                               result_stall;
    sklf_pkg::result_t                  result_item;
    logic                               cfg_we;
    logic [sklf_pkg::CFG_IDX_WIDTH-1:0] cfg_index;
    logic [sklf_pkg::CFG_WIDTH-1:0]     cfg_data;

    // Predicted filter state and noise settings
    logic signed [sklf_pkg::SAMPLE_WIDTH-1:0] pred_estimate = '0;
    logic [sklf_pkg::VAR_WIDTH-1:0]           pred_variance = '0;
    bit                                       pred_primed   = 1'b0;
    logic [sklf_pkg::CFG_WIDTH-1:0]           noise_q       = sklf_pkg::PROCESS_NOISE_RESET;
    logic [sklf_pkg::CFG_WIDTH-1:0]           noise_r       = sklf_pkg::MEASUREMENT_NOISE_RESET;

    sklf_pkg::result_t pending_estimates[$];
    int      mismatch_count = 0;
    int      send_idle_pct  = 0;
    int      recv_idle_pct  = 0;
    bit      offering       = 1'b0;
    int      rssi_level     = -17920;

    // Long receiver hold-off: tests bump hold_requests, the stall process counts
    int      hold_requests  = 0;
    int      hold_len       = 0;
    int      hold_served    = 0;
    int      hold_left      = 0;

    scalar_kalman_filter dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample_item  (sample_item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_item  (result_item),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Watchdog
    initial
    begin
        #8_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // One filter step: restart/first sample loads, otherwise predict, gain, update, shrink
    function automatic sklf_pkg::result_t filter_step_model(input sklf_pkg::sample_t s);
        sklf_pkg::result_t res;
        longint      meas;
        longint      diff;
        longint      prod;
        longint      gain_s;
        longint      x;
        logic [63:0] var_w;
        logic [63:0] q_w;
        logic [63:0] r_w;
        logic [63:0] p;
        logic [63:0] den;
        logic [63:0] k;
        logic [63:0] shrunk;
        meas = longint'(s.measurement);
        if (s.restart || !pred_primed)
        begin
            pred_estimate          = s.measurement;
            pred_variance          = {8'h00, noise_r, 8'h00};
            pred_primed            = 1'b1;
            res.estimate           = s.measurement;
            res.was_initialization = 1'b1;
        end
        else
        begin
            var_w = {32'd0, pred_variance};
            q_w   = {48'd0, noise_q};
            r_w   = {48'd0, noise_r};
            // predict, saturating
            p = var_w + (q_w << 8);
            if (p > VAR_MAX)
                p = VAR_MAX;
            // gain, capped just under 1.0
            den = p + (r_w << 8);
            if (den == 64'd0)
                k = GAIN_MAX;
            else
            begin
                k = (p << GAIN_BITS) / den;
                if (k > GAIN_MAX)
                    k = GAIN_MAX;
            end
            // estimate update, round half up, clamp
            gain_s = k;
            diff   = meas - longint'(pred_estimate);
            prod   = gain_s * diff + longint'(GAIN_ONE >> 1);
            x      = longint'(pred_estimate) + (prod >>> GAIN_BITS);
            if (x > EST_MAX)
                x = EST_MAX;
            if (x < EST_MIN)
                x = EST_MIN;
            pred_estimate = x[sklf_pkg::SAMPLE_WIDTH-1:0];
            // variance shrink, truncated
            shrunk        = ((GAIN_ONE - k) * p) >> GAIN_BITS;
            pred_variance = shrunk[sklf_pkg::VAR_WIDTH-1:0];
            res.estimate           = pred_estimate;
            res.was_initialization = 1'b0;
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("MISMATCH at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // Result checker
    always @(posedge clk)
    begin : result_check
        sklf_pkg::result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_estimates.size() == 0)
                report_mismatch("unexpected result, estimate", result_item.estimate, 0);
            else
            begin
                want = pending_estimates.pop_front();
                if (result_item.estimate !== want.estimate)
                    report_mismatch("estimate", result_item.estimate, want.estimate);
                if (result_item.was_initialization !== want.was_initialization)
                    report_mismatch("was_initialization", result_item.was_initialization,
                                    want.was_initialization);
            end
        end
    end

    // Receiver stall: random idling plus requested long hold-offs
    always @(posedge clk)
    begin
        if (hold_served != hold_requests)
        begin
            hold_served = hold_requests;
            hold_left   = hold_len;
        end
        if (hold_left > 0)
        begin
            result_stall <= 1'b1;
            hold_left--;
        end
        else
            result_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // Offer one item, with a random gap first; predict it when accepted
    task automatic send_sample(input logic [sklf_pkg::SAMPLE_WIDTH-1:0] meas, input logic rs);
        sklf_pkg::sample_t s;
        s.measurement = meas;
        s.restart     = rs;
        if ($urandom_range(99) < send_idle_pct)
        begin
            if (offering)
                sample_valid <= 1'b0;
            offering = 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct)
                @(posedge clk);
        end
        sample_valid <= 1'b1;
        sample_item  <= s;
        offering      = 1'b1;
        do
            @(posedge clk);
        while (sample_stall);
        pending_estimates.push_back(filter_step_model(s));
    endtask

    // Stop offering and wait for every outstanding result
    task automatic drain();
        if (offering)
            sample_valid <= 1'b0;
        offering = 1'b0;
        while (pending_estimates.size() != 0)
            @(posedge clk);
    endtask

    task automatic put_register(input logic [sklf_pkg::CFG_IDX_WIDTH-1:0] idx,
                                input logic [sklf_pkg::CFG_WIDTH-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        case (idx)
            sklf_pkg::CFG_PROCESS_NOISE:     noise_q = value;
            sklf_pkg::CFG_MEASUREMENT_NOISE: noise_r = value;
            default: ;
        endcase
    endtask

    // Idle the block, write q and r, then a write to an unlisted index
    task automatic write_noise(input logic [sklf_pkg::CFG_WIDTH-1:0] q,
                               input logic [sklf_pkg::CFG_WIDTH-1:0] r);
        drain();
        put_register(sklf_pkg::CFG_PROCESS_NOISE, q);
        put_register(sklf_pkg::CFG_MEASUREMENT_NOISE, r);
        put_register($urandom_range(1) ? CFG_SPARE_A : CFG_SPARE_B, CFG_BITS'($urandom));
        cfg_we <= 1'b0;
    endtask

    // Mostly a wandering signal level with noise, some full-range and edge values
    function automatic logic [sklf_pkg::SAMPLE_WIDTH-1:0] pick_measurement();
        int m;
        case ($urandom_range(9))
            6, 7:    m = $urandom;
            8:       m = $urandom_range(1) ? 32767 : -32768;
            9:       m = int'($urandom_range(16)) - 8;
            default:
            begin
                rssi_level += int'($urandom_range(512)) - 256;
                if (rssi_level < -25600)
                    rssi_level = -25600;
                if (rssi_level > -7680)
                    rssi_level = -7680;
                m = rssi_level + int'($urandom_range(1024)) - 512;
            end
        endcase
        return m[sklf_pkg::SAMPLE_WIDTH-1:0];
    endfunction

    function automatic logic [sklf_pkg::CFG_WIDTH-1:0] pick_process_noise();
        case ($urandom_range(4))
            0:       return '0;
            1:       return '1;
            2:       return CFG_BITS'($urandom_range(64, 1));
            3:       return CFG_BITS'($urandom_range(2048, 65));
            default: return CFG_BITS'($urandom);
        endcase
    endfunction

    function automatic logic [sklf_pkg::CFG_WIDTH-1:0] pick_measurement_noise();
        if ($urandom_range(19) == 0)
            return '0;
        case ($urandom_range(4))
            0:       return 16'd1;
            1:       return '1;
            2:       return CFG_BITS'($urandom_range(512, 1));
            3:       return CFG_BITS'($urandom_range(8192, 256));
            default: return CFG_BITS'($urandom);
        endcase
    endfunction

    // First sample after reset initializes without the restart flag; defaults q=26, r=256
    task automatic test_first_sample();
        send_sample(16'hBA00, 1'b0);
        send_sample(16'hBB00, 1'b0);
        send_sample(16'hB900, 1'b0);
        send_sample(16'hBA00, 1'b0);
    endtask

    // Field extremes, alternating bit patterns and restarts
    task automatic test_field_extremes();
        send_sample(16'h7FFF, 1'b0);
        send_sample(16'h8000, 1'b0);
        send_sample(16'h7FFF, 1'b0);
        send_sample(16'h0000, 1'b1);
        send_sample(16'hFFFF, 1'b0);
        send_sample(16'h8000, 1'b1);
        send_sample(16'h7FFF, 1'b0);
        send_sample(16'h5555, 1'b0);
        send_sample(16'hAAAA, 1'b1);
    endtask

    // Zero noise gives a zero divisor, then a gain of one that saturates; then max noise
    task automatic test_noise_extremes();
        write_noise('0, '0);
        send_sample(16'h1234, 1'b1);
        send_sample(16'h8000, 1'b0);
        write_noise(16'd26, '0);
        send_sample(16'h7FFF, 1'b0);
        send_sample(16'hC000, 1'b0);
        write_noise('1, '1);
        send_sample(16'h8000, 1'b1);
        send_sample(16'h7FFF, 1'b0);
        send_sample(16'h7FFF, 1'b0);
    endtask

    // Long receiver hold-off fills the block while items keep coming, then a full pause
    task automatic test_backpressure();
        write_noise(16'd40, 16'd300);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_len      = 400;
        hold_requests++;
        for (int i = 0; i < 16; i++)
            send_sample(pick_measurement(), i == 0);
        drain();
    endtask

    // Random stream under one idling setting, retuning the noise every so often
    task automatic test_random_stream(input int items, input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (int i = 0; i < items; i++)
        begin
            if (i != 0 && i % 75 == 0)
                write_noise(pick_process_noise(), pick_measurement_noise());
            send_sample(pick_measurement(), $urandom_range(24) == 0);
        end
    endtask

    initial
    begin
        rst_n        <= 1'b0;
        sample_valid <= 1'b0;
        sample_item  <= '0;
        cfg_we       <= 1'b0;
        cfg_index    <= sklf_pkg::CFG_PROCESS_NOISE;
        cfg_data     <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        test_first_sample();
        test_field_extremes();
        test_noise_extremes();
        test_backpressure();
        write_noise(sklf_pkg::PROCESS_NOISE_RESET, sklf_pkg::MEASUREMENT_NOISE_RESET);
        test_random_stream(300, 28, 69);
        write_noise(16'd1, '1);
        test_random_stream(300, 69, 28);
        write_noise('1, 16'd1);
        test_random_stream(300, 0, 0);

        // Let the last results settle
        drain();
        repeat (STEP_LATENCY + 8) @(posedge clk);
        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
